FILE: hdl/lsm_pkg.sv
`default_nettype none
package lsm_pkg;

    // counter widths
    localparam int PACKET_COUNT_WIDTH = 32;
    localparam int BYTE_COUNT_WIDTH   = 48;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int RTT_W      = 20;
    localparam int BCNT_W     = 16;
    localparam int ELAPSED_W  = 32;
    localparam int RATE_W     = 52;
    localparam int LOSS_W     = 7;
    localparam int PKT_OUT_W  = 32;
    localparam int BYTE_OUT_W = 48;

    // arithmetic constants
    localparam int MEAN_WEIGHT   = 9;
    localparam int MEAN_DIVISOR  = 10;
    localparam int PERCENT_SCALE = 100;
    localparam int BIT_SHIFT     = 3;

    localparam logic [LOSS_W-1:0] LOSS_FULL    = LOSS_W'(PERCENT_SCALE);
    localparam logic [RTT_W-1:0]  RTT_ALL_ONES = {RTT_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

    // dividend widths of the three divisions
    localparam int MEAN_DIV_W = RTT_W + 4;
    localparam int RATE_DIV_W = BYTE_COUNT_WIDTH + BIT_SHIFT;
    localparam int LOSS_DIV_W = PACKET_COUNT_WIDTH + LOSS_W;

    // divide by ten as multiply by ceil(2^27/10), exact for sums below 2^26
    localparam int                    MEAN_PROD_W      = 2 * MEAN_DIV_W;
    localparam logic [MEAN_DIV_W-1:0] MEAN_RECIP       = MEAN_DIV_W'(13421773);
    localparam int                    MEAN_RECIP_SHIFT = 27;

    // shared divider sizing
    localparam int DIV_QA_W = (RATE_DIV_W > LOSS_DIV_W) ? RATE_DIV_W : LOSS_DIV_W;
    localparam int DIV_QB_W = (MEAN_DIV_W > RATE_W) ? MEAN_DIV_W : RATE_W;
    localparam int DIV_Q_W  = (DIV_QA_W > DIV_QB_W) ? DIV_QA_W : DIV_QB_W;
    localparam int DIV_D_W  = (ELAPSED_W > PACKET_COUNT_WIDTH) ? ELAPSED_W
                                                               : PACKET_COUNT_WIDTH;
    localparam int STEP_W   = $clog2(DIV_Q_W + 1);

    // iteration counts; the loss quotient stays below 128
    localparam int RATE_STEPS = RATE_DIV_W;
    localparam int LOSS_STEPS = LOSS_W;

    // event codes
    typedef enum logic [CMD_W-1:0] {
        CMD_RTT  = 3'd0,
        CMD_SENT = 3'd1,
        CMD_RECV = 3'd2,
        CMD_LOST = 3'd3,
        CMD_TICK = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_RATE,
        DIV_LOSS
    } t_div_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_DIV,
        S_SNAP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    div_start;
        t_div_op div_op;
        logic    div_write;
        logic    loss_fix;
        logic    snap;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic mean_div_in;
        logic rate_in;
        logic loss_in;
        logic elapsed_nz;
        logic loss_direct;
        logic div_busy;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: hdl/link_statistics_monitor.sv
`default_nettype none
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_cmd, i_rtt_sample, i_byte_count
// output    out        o_out_valid / i_out_stall snapshot of all statistics
//
// one beat at a time: S_IDLE takes a beat; S_PICK starts a shared divider pass,
// waited on in S_DIV, for throughput (51 steps; sent, tick with nonzero elapsed)
// and loss (7 steps; sent, lost); an rtt average update, a direct loss or a held
// throughput is done in S_PICK alone; S_SNAP takes the snapshot, then S_IDLE again.
// synchronous active-low reset clears all statistics, lowest rtt to all ones.
// a stalled output holds its result; the next beat is worked meanwhile, then waits.
module link_statistics_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [lsm_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [lsm_pkg::RTT_W-1:0]      i_rtt_sample,
    input  wire logic [lsm_pkg::BCNT_W-1:0]     i_byte_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_sent_packets,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_received_packets,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_lost_packets,
    output logic [lsm_pkg::LOSS_W-1:0]          o_loss_percent,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_latest,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_average,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_lowest,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_highest,
    output logic [lsm_pkg::RATE_W-1:0]          o_bit_rate,
    output logic [lsm_pkg::BYTE_OUT_W-1:0]      o_sent_bytes,
    output logic [lsm_pkg::BYTE_OUT_W-1:0]      o_received_bytes
);
    import lsm_pkg::*;

    t_ctrl_cmd  ctrl;
    t_dp_status status;

    // sequencing
    lsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_ctrl      (ctrl)
    );

    // statistics and division
    lsm_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .o_status           (status),
        .i_cmd              (i_cmd),
        .i_rtt_sample       (i_rtt_sample),
        .i_byte_count       (i_byte_count),
        .o_sent_packets     (o_sent_packets),
        .o_received_packets (o_received_packets),
        .o_lost_packets     (o_lost_packets),
        .o_loss_percent     (o_loss_percent),
        .o_rtt_latest       (o_rtt_latest),
        .o_rtt_average      (o_rtt_average),
        .o_rtt_lowest       (o_rtt_lowest),
        .o_rtt_highest      (o_rtt_highest),
        .o_bit_rate         (o_bit_rate),
        .o_sent_bytes       (o_sent_bytes),
        .o_received_bytes   (o_received_bytes)
    );

endmodule
`default_nettype wire

FILE: hdl/lsm_divider.sv
`default_nettype none
module lsm_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lsm_pkg::DIV_D_W-1:0] i_rem,
    input  wire logic [lsm_pkg::DIV_Q_W-1:0] i_quo,
    input  wire logic [lsm_pkg::DIV_D_W-1:0] i_divisor,
    input  wire logic [lsm_pkg::STEP_W-1:0]  i_steps,
    output logic                             o_busy,
    output logic [lsm_pkg::DIV_Q_W-1:0]      o_quo
);
    import lsm_pkg::*;

    logic [DIV_D_W-1:0] r_rem, n_rem;
    logic [DIV_Q_W-1:0] r_quo, n_quo;
    logic [DIV_D_W-1:0] r_div;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [DIV_D_W:0]   trial;

    // one restoring step: shift in the next dividend bit, try subtract
    always_comb begin
        trial = {r_rem, r_quo[DIV_Q_W-1]} - {1'b0, r_div};
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (r_cnt != '0) begin
            n_cnt = r_cnt - STEP_W'(1);
            if (!trial[DIV_D_W]) begin
                n_rem = trial[DIV_D_W-1:0];
                n_quo = {r_quo[DIV_Q_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DIV_D_W-2:0], r_quo[DIV_Q_W-1]};
                n_quo = {r_quo[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_quo <= i_quo;
            r_div <= i_divisor;
        end else begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

FILE: hdl/lsm_datapath.sv
`default_nettype none
module lsm_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lsm_pkg::t_ctrl_cmd             i_ctrl,
    output lsm_pkg::t_dp_status                 o_status,
    input  wire logic [lsm_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [lsm_pkg::RTT_W-1:0]      i_rtt_sample,
    input  wire logic [lsm_pkg::BCNT_W-1:0]     i_byte_count,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_sent_packets,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_received_packets,
    output logic [lsm_pkg::PKT_OUT_W-1:0]       o_lost_packets,
    output logic [lsm_pkg::LOSS_W-1:0]          o_loss_percent,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_latest,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_average,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_lowest,
    output logic [lsm_pkg::RTT_W-1:0]           o_rtt_highest,
    output logic [lsm_pkg::RATE_W-1:0]          o_bit_rate,
    output logic [lsm_pkg::BYTE_OUT_W-1:0]      o_sent_bytes,
    output logic [lsm_pkg::BYTE_OUT_W-1:0]      o_received_bytes
);
    import lsm_pkg::*;

    localparam logic [DIV_Q_W-1:0] RATE_Q_MASK = {DIV_Q_W{1'b1}} >> (DIV_Q_W - RATE_DIV_W);

    // statistics state
    logic [PACKET_COUNT_WIDTH-1:0] r_sent_cnt, r_recv_cnt, r_lost_cnt;
    logic [BYTE_COUNT_WIDTH-1:0]   r_sent_bytes, r_recv_bytes;
    logic [RTT_W-1:0]              r_rtt_now, r_rtt_mean, r_rtt_floor, r_rtt_ceil;
    logic [ELAPSED_W-1:0]          r_elapsed;
    logic [RATE_W-1:0]             r_rate;
    logic [LOSS_W-1:0]             r_loss;
    logic [MEAN_DIV_W-1:0]         r_mean_sum;

    // snapshot registers
    logic [PKT_OUT_W-1:0]  r_snap_sent, r_snap_recv, r_snap_lost;
    logic [LOSS_W-1:0]     r_snap_loss;
    logic [RTT_W-1:0]      r_snap_now, r_snap_mean, r_snap_floor, r_snap_ceil;
    logic [RATE_W-1:0]     r_snap_rate;
    logic [BYTE_OUT_W-1:0] r_snap_sent_bytes, r_snap_recv_bytes;

    // divider operands
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [RTT_W-1:0]       mean_quo;
    logic [LOSS_DIV_W-1:0]  loss_dividend;
    logic [RATE_DIV_W-1:0]  rate_dividend;
    logic [DIV_D_W-1:0]     div_rem;
    logic [DIV_Q_W-1:0]     div_quo_init;
    logic [DIV_D_W-1:0]     div_divisor;
    logic [STEP_W-1:0]      div_steps;
    logic                   div_busy;
    logic [DIV_Q_W-1:0]     div_quo;
    logic [DIV_Q_W-1:0]     rate_q;
    logic [RATE_W-1:0]      rate_sat;

    // average update: weighted sum times the reciprocal of ten
    assign mean_prod     = MEAN_PROD_W'(r_mean_sum) * MEAN_PROD_W'(MEAN_RECIP);
    assign mean_quo      = mean_prod[MEAN_RECIP_SHIFT +: RTT_W];

    // dividends
    assign loss_dividend = LOSS_DIV_W'(r_lost_cnt) * LOSS_DIV_W'(PERCENT_SCALE);
    assign rate_dividend = RATE_DIV_W'(r_sent_bytes) << BIT_SHIFT;

    // operand select for the shared divider
    always_comb begin
        unique case (i_ctrl.div_op)
            DIV_RATE: begin
                div_rem      = '0;
                div_quo_init = DIV_Q_W'(rate_dividend) << (DIV_Q_W - RATE_DIV_W);
                div_divisor  = DIV_D_W'(r_elapsed);
                div_steps    = STEP_W'(RATE_STEPS);
            end
            DIV_LOSS: begin
                // upper bits preloaded as remainder, quotient fits in seven steps
                div_rem      = DIV_D_W'(loss_dividend >> LOSS_STEPS);
                div_quo_init = DIV_Q_W'(loss_dividend) << (DIV_Q_W - LOSS_STEPS);
                div_divisor  = DIV_D_W'(r_sent_cnt);
                div_steps    = STEP_W'(LOSS_STEPS);
            end
            default: begin
                div_rem      = '0;
                div_quo_init = '0;
                div_divisor  = '0;
                div_steps    = '0;
            end
        endcase
    end

    lsm_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_ctrl.div_start),
        .i_rem     (div_rem),
        .i_quo     (div_quo_init),
        .i_divisor (div_divisor),
        .i_steps   (div_steps),
        .o_busy    (div_busy),
        .o_quo     (div_quo)
    );

    // throughput quotient with saturation
    assign rate_q   = div_quo & RATE_Q_MASK;
    assign rate_sat = (rate_q > DIV_Q_W'(RATE_MAX)) ? RATE_MAX : rate_q[RATE_W-1:0];

    // status back to the controller
    always_comb begin
        o_status.mean_div_in = (i_cmd == CMD_RTT) && (r_rtt_mean != '0);
        o_status.rate_in     = (i_cmd == CMD_SENT) || (i_cmd == CMD_TICK);
        o_status.loss_in     = (i_cmd == CMD_SENT) || (i_cmd == CMD_LOST);
        o_status.elapsed_nz  = (r_elapsed != '0);
        o_status.loss_direct = (r_sent_cnt == '0) || (r_lost_cnt >= r_sent_cnt);
        o_status.div_busy    = div_busy;
    end

    // counters and rtt tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_cnt   <= '0;
            r_recv_cnt   <= '0;
            r_lost_cnt   <= '0;
            r_sent_bytes <= '0;
            r_recv_bytes <= '0;
            r_rtt_now    <= '0;
            r_rtt_mean   <= '0;
            r_rtt_floor  <= RTT_ALL_ONES;
            r_rtt_ceil   <= '0;
            r_elapsed    <= '0;
            r_rate       <= '0;
            r_loss       <= '0;
        end else begin
            if (i_ctrl.accept) begin
                unique case (i_cmd)
                    CMD_RTT: begin
                        r_rtt_now <= i_rtt_sample;
                        if (i_rtt_sample < r_rtt_floor) begin
                            r_rtt_floor <= i_rtt_sample;
                        end
                        if (i_rtt_sample > r_rtt_ceil) begin
                            r_rtt_ceil <= i_rtt_sample;
                        end
                        // seed the average while it is zero
                        if (r_rtt_mean == '0) begin
                            r_rtt_mean <= i_rtt_sample;
                        end
                    end
                    CMD_SENT: begin
                        r_sent_cnt   <= r_sent_cnt + PACKET_COUNT_WIDTH'(1);
                        r_sent_bytes <= r_sent_bytes + BYTE_COUNT_WIDTH'(i_byte_count);
                    end
                    CMD_RECV: begin
                        r_recv_cnt   <= r_recv_cnt + PACKET_COUNT_WIDTH'(1);
                        r_recv_bytes <= r_recv_bytes + BYTE_COUNT_WIDTH'(i_byte_count);
                    end
                    CMD_LOST: begin
                        r_lost_cnt <= r_lost_cnt + PACKET_COUNT_WIDTH'(1);
                    end
                    CMD_TICK: begin
                        r_elapsed <= r_elapsed + ELAPSED_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            // division write back
            if (i_ctrl.div_write) begin
                unique case (i_ctrl.div_op)
                    DIV_MEAN: r_rtt_mean <= mean_quo;
                    DIV_RATE: r_rate     <= rate_sat;
                    DIV_LOSS: r_loss     <= div_quo[LOSS_W-1:0];
                    default: begin
                    end
                endcase
            end
            // loss without division: nothing sent, or all lost
            if (i_ctrl.loss_fix) begin
                r_loss <= (r_sent_cnt == '0) ? '0 : LOSS_FULL;
            end
        end
    end

    // weighted sum kept for the average update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_mean_sum <= MEAN_DIV_W'(r_rtt_mean) * MEAN_DIV_W'(MEAN_WEIGHT)
                        + MEAN_DIV_W'(i_rtt_sample);
        end
    end

    // result snapshot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.snap) begin
            r_snap_sent       <= PKT_OUT_W'(r_sent_cnt);
            r_snap_recv       <= PKT_OUT_W'(r_recv_cnt);
            r_snap_lost       <= PKT_OUT_W'(r_lost_cnt);
            r_snap_loss       <= r_loss;
            r_snap_now        <= r_rtt_now;
            r_snap_mean       <= r_rtt_mean;
            r_snap_floor      <= r_rtt_floor;
            r_snap_ceil       <= r_rtt_ceil;
            r_snap_rate       <= r_rate;
            r_snap_sent_bytes <= BYTE_OUT_W'(r_sent_bytes);
            r_snap_recv_bytes <= BYTE_OUT_W'(r_recv_bytes);
        end
    end

    assign o_sent_packets     = r_snap_sent;
    assign o_received_packets = r_snap_recv;
    assign o_lost_packets     = r_snap_lost;
    assign o_loss_percent     = r_snap_loss;
    assign o_rtt_latest       = r_snap_now;
    assign o_rtt_average      = r_snap_mean;
    assign o_rtt_lowest       = r_snap_floor;
    assign o_rtt_highest      = r_snap_ceil;
    assign o_bit_rate         = r_snap_rate;
    assign o_sent_bytes       = r_snap_sent_bytes;
    assign o_received_bytes   = r_snap_recv_bytes;

    // loss never above full scale
    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loss <= LOSS_FULL)
        else $error("loss percent above 100");

    // lowest never above highest once a sample was seen
    a_rtt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rtt_floor <= r_rtt_ceil) || ((r_rtt_floor == RTT_ALL_ONES) && (r_rtt_ceil == '0)))
        else $error("rtt lowest above highest");

endmodule
`default_nettype wire

FILE: hdl/lsm_ctrl.sv
`default_nettype none
module lsm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    input  wire lsm_pkg::t_dp_status i_status,
    output lsm_pkg::t_ctrl_cmd       o_ctrl
);
    import lsm_pkg::*;

    t_state  r_state, n_state;
    t_div_op r_op;
    logic    r_need_mean, n_need_mean;
    logic    r_need_rate, n_need_rate;
    logic    r_need_loss, n_need_loss;
    logic    r_out_valid, n_out_valid;
    logic    any_need;

    assign any_need = r_need_mean || r_need_rate || r_need_loss;

    // command outputs
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.div_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.accept = i_in_valid;
            end
            S_PICK: begin
                priority if (r_need_mean) begin
                    // average written straight from the reciprocal product
                    o_ctrl.div_write = 1'b1;
                    o_ctrl.div_op    = DIV_MEAN;
                end else if (r_need_rate) begin
                    o_ctrl.div_start = i_status.elapsed_nz;
                    o_ctrl.div_op    = DIV_RATE;
                end else if (r_need_loss) begin
                    o_ctrl.div_start = !i_status.loss_direct;
                    o_ctrl.loss_fix  = i_status.loss_direct;
                    o_ctrl.div_op    = DIV_LOSS;
                end else begin
                end
            end
            S_DIV: begin
                o_ctrl.div_write = !i_status.div_busy;
            end
            S_SNAP: begin
                o_ctrl.snap = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                priority if (o_ctrl.div_start) begin
                    n_state = S_DIV;
                end else if (!any_need) begin
                    n_state = S_SNAP;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_PICK;
                end
            end
            S_SNAP: begin
                if (o_ctrl.snap) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // pending division flags, cleared one at a time in priority order
    always_comb begin
        n_need_mean = r_need_mean;
        n_need_rate = r_need_rate;
        n_need_loss = r_need_loss;
        if (o_ctrl.accept) begin
            n_need_mean = i_status.mean_div_in;
            n_need_rate = i_status.rate_in;
            n_need_loss = i_status.loss_in;
        end else if (r_state == S_PICK) begin
            priority if (r_need_mean) begin
                n_need_mean = 1'b0;
            end else if (r_need_rate) begin
                n_need_rate = 1'b0;
            end else begin
                n_need_loss = 1'b0;
            end
        end
    end

    // output beat valid
    always_comb begin
        priority if (o_ctrl.snap) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_need_mean <= 1'b0;
            r_need_rate <= 1'b0;
            r_need_loss <= 1'b0;
            r_out_valid <= 1'b0;
            r_op        <= DIV_MEAN;
        end else begin
            r_state     <= n_state;
            r_need_mean <= n_need_mean;
            r_need_rate <= n_need_rate;
            r_need_loss <= n_need_loss;
            r_out_valid <= n_out_valid;
            if (o_ctrl.div_start) begin
                r_op <= o_ctrl.div_op;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // an accepted beat blocks the input on the next cycle
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.accept |=> o_in_stall)
        else $error("input not blocked after accept");

    // a new snapshot never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.snap |-> (!r_out_valid || !i_out_stall))
        else $error("snapshot overwrote a pending result");

    // the divider is started only while idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.div_start |-> !i_status.div_busy)
        else $error("divider started while busy");

    // no division left pending when the result is taken
    a_snap_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.snap |-> !any_need)
        else $error("snapshot with division pending");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lsm_pkg::*;

    // codes outside the defined event set
    localparam logic [CMD_W-1:0]  CMD_UNDEF_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_UNDEF_LAST  = 3'd7;
    localparam logic [BCNT_W-1:0] BYTES_ALL_ONES  = {BCNT_W{1'b1}};

    localparam int RANDOM_EVENTS  = 1050;
    localparam int CALM_TAIL      = 150;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [CMD_W-1:0]  code;
        logic [RTT_W-1:0]  rtt;
        logic [BCNT_W-1:0] nbytes;
    } t_link_event;

    typedef struct {
        logic [PKT_OUT_W-1:0]  sent_packets;
        logic [PKT_OUT_W-1:0]  received_packets;
        logic [PKT_OUT_W-1:0]  lost_packets;
        logic [LOSS_W-1:0]     loss_percent;
        logic [RTT_W-1:0]      rtt_latest;
        logic [RTT_W-1:0]      rtt_average;
        logic [RTT_W-1:0]      rtt_lowest;
        logic [RTT_W-1:0]      rtt_highest;
        logic [RATE_W-1:0]     bit_rate;
        logic [BYTE_OUT_W-1:0] sent_bytes;
        logic [BYTE_OUT_W-1:0] received_bytes;
    } t_snapshot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic [CMD_W-1:0]  i_cmd = '0;
    logic [RTT_W-1:0]  i_rtt_sample = '0;
    logic [BCNT_W-1:0] i_byte_count = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PKT_OUT_W-1:0]  o_sent_packets;
    logic [PKT_OUT_W-1:0]  o_received_packets;
    logic [PKT_OUT_W-1:0]  o_lost_packets;
    logic [LOSS_W-1:0]     o_loss_percent;
    logic [RTT_W-1:0]      o_rtt_latest;
    logic [RTT_W-1:0]      o_rtt_average;
    logic [RTT_W-1:0]      o_rtt_lowest;
    logic [RTT_W-1:0]      o_rtt_highest;
    logic [RATE_W-1:0]     o_bit_rate;
    logic [BYTE_OUT_W-1:0] o_sent_bytes;
    logic [BYTE_OUT_W-1:0] o_received_bytes;

    // predicted link statistics
    logic [PACKET_COUNT_WIDTH-1:0] m_sent_pkts  = '0;
    logic [PACKET_COUNT_WIDTH-1:0] m_recv_pkts  = '0;
    logic [PACKET_COUNT_WIDTH-1:0] m_lost_pkts  = '0;
    logic [BYTE_COUNT_WIDTH-1:0]   m_sent_bytes = '0;
    logic [BYTE_COUNT_WIDTH-1:0]   m_recv_bytes = '0;
    logic [RTT_W-1:0]              m_rtt_now    = '0;
    logic [RTT_W-1:0]              m_rtt_avg    = '0;
    logic [RTT_W-1:0]              m_rtt_low    = RTT_ALL_ONES;
    logic [RTT_W-1:0]              m_rtt_high   = '0;
    logic [ELAPSED_W-1:0]          m_elapsed    = '0;
    logic [RATE_W-1:0]             m_rate       = '0;

    t_link_event pending_events [$];
    t_snapshot   snapshot_q [$];

    logic in_fire = 1'b0;
    int   total_items = 0;
    int   calm_from = 0;
    int   events_taken = 0;
    int   snapshots_checked = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   code_hits [8];
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   held_once = 1'b0;

    link_statistics_monitor u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_rtt_sample       (i_rtt_sample),
        .i_byte_count       (i_byte_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sent_packets     (o_sent_packets),
        .o_received_packets (o_received_packets),
        .o_lost_packets     (o_lost_packets),
        .o_loss_percent     (o_loss_percent),
        .o_rtt_latest       (o_rtt_latest),
        .o_rtt_average      (o_rtt_average),
        .o_rtt_lowest       (o_rtt_lowest),
        .o_rtt_highest      (o_rtt_highest),
        .o_bit_rate         (o_bit_rate),
        .o_sent_bytes       (o_sent_bytes),
        .o_received_bytes   (o_received_bytes)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one link event to the predicted statistics and return the snapshot
    function automatic t_snapshot advance_link_stats(logic [CMD_W-1:0] code,
                                                     logic [RTT_W-1:0] x,
                                                     logic [BCNT_W-1:0] nbytes);
        t_snapshot   s;
        logic [127:0] wide;
        case (code)
            CMD_RTT: begin
                m_rtt_now = x;
                if (x < m_rtt_low) m_rtt_low = x;
                if (x > m_rtt_high) m_rtt_high = x;
                // a zero mean is seeded from the sample
                if (m_rtt_avg == '0) begin
                    m_rtt_avg = x;
                end else begin
                    wide = (128'(m_rtt_avg) * MEAN_WEIGHT + 128'(x)) / MEAN_DIVISOR;
                    m_rtt_avg = RTT_W'(wide);
                end
            end
            CMD_SENT: begin
                m_sent_pkts  = m_sent_pkts + 1'b1;
                m_sent_bytes = m_sent_bytes + BYTE_COUNT_WIDTH'(nbytes);
            end
            CMD_RECV: begin
                m_recv_pkts  = m_recv_pkts + 1'b1;
                m_recv_bytes = m_recv_bytes + BYTE_COUNT_WIDTH'(nbytes);
            end
            CMD_LOST: m_lost_pkts = m_lost_pkts + 1'b1;
            CMD_TICK: m_elapsed = m_elapsed + 1'b1;
            default: ;
        endcase

        // throughput holds while no tick has elapsed
        if (m_elapsed != '0) begin
            wide = (128'(m_sent_bytes) << BIT_SHIFT) / 128'(m_elapsed);
            m_rate = (wide > 128'(RATE_MAX)) ? RATE_MAX : RATE_W'(wide);
        end

        if (m_sent_pkts == '0) begin
            s.loss_percent = '0;
        end else if (m_lost_pkts >= m_sent_pkts) begin
            s.loss_percent = LOSS_FULL;
        end else begin
            wide = (128'(m_lost_pkts) * PERCENT_SCALE) / 128'(m_sent_pkts);
            s.loss_percent = LOSS_W'(wide);
        end

        s.sent_packets     = PKT_OUT_W'(m_sent_pkts);
        s.received_packets = PKT_OUT_W'(m_recv_pkts);
        s.lost_packets     = PKT_OUT_W'(m_lost_pkts);
        s.rtt_latest       = m_rtt_now;
        s.rtt_average      = m_rtt_avg;
        s.rtt_lowest       = m_rtt_low;
        s.rtt_highest      = m_rtt_high;
        s.bit_rate         = m_rate;
        s.sent_bytes       = BYTE_OUT_W'(m_sent_bytes);
        s.received_bytes   = BYTE_OUT_W'(m_recv_bytes);
        return s;
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %0d got %0d", $time, label, want, got);
        end
    endtask

    // sender: drives one beat at a time, holds it while stalled
    always @(negedge i_clk) begin : sender
        t_link_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // stalled beat keeps its payload
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            i_cmd        <= ev.code;
            i_rtt_sample <= ev.rtt;
            i_byte_count <= ev.nbytes;
            i_in_valid   <= 1'b1;
            if (events_taken < calm_from && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 18);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!held_once && events_taken >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (events_taken < calm_from && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor: predicts on input beats, checks output beats, watches for hangs
    always @(posedge i_clk) begin : monitor
        t_snapshot want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                snapshot_q.push_back(advance_link_stats(i_cmd, i_rtt_sample, i_byte_count));
                events_taken++;
                code_hits[i_cmd]++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (snapshot_q.size() == 0) begin
                    error_count++;
                    $display("%0t: snapshot beat with none expected", $time);
                end else begin
                    want = snapshot_q.pop_front();
                    snapshots_checked++;
                    compare_field("sent_packets", want.sent_packets, o_sent_packets);
                    compare_field("received_packets", want.received_packets,
                                  o_received_packets);
                    compare_field("lost_packets", want.lost_packets, o_lost_packets);
                    compare_field("loss_percent", want.loss_percent, o_loss_percent);
                    compare_field("rtt_latest", want.rtt_latest, o_rtt_latest);
                    compare_field("rtt_average", want.rtt_average, o_rtt_average);
                    compare_field("rtt_lowest", want.rtt_lowest, o_rtt_lowest);
                    compare_field("rtt_highest", want.rtt_highest, o_rtt_highest);
                    compare_field("bit_rate", want.bit_rate, o_bit_rate);
                    compare_field("sent_bytes", want.sent_bytes, o_sent_bytes);
                    compare_field("received_bytes", want.received_bytes, o_received_bytes);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        t_link_event ev;
        int wt_rtt, wt_sent, wt_recv, wt_lost, wt_tick, wt_undef, wt_sum;
        int seg_left, pick, rtt_mode, undef_hits;

        foreach (code_hits[k]) code_hits[k] = 0;

        // directed: loss with nothing sent, clamp, throughput hold
        pending_events.push_back('{CMD_LOST, RTT_ALL_ONES, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_LOST, '0, '0});
        pending_events.push_back('{CMD_SENT, '0, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_SENT, RTT_ALL_ONES, '0});
        pending_events.push_back('{CMD_RECV, '0, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_RECV, RTT_ALL_ONES, '0});
        // mean seeded, decays to zero, seeded again
        pending_events.push_back('{CMD_RTT, 20'd1, '0});
        pending_events.push_back('{CMD_RTT, '0, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_RTT, 20'd7, '0});
        pending_events.push_back('{CMD_RTT, RTT_ALL_ONES, '0});
        pending_events.push_back('{CMD_RTT, '0, '0});
        pending_events.push_back('{CMD_RTT, 20'd3000, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_TICK, '0, '0});
        pending_events.push_back('{CMD_SENT, '0, 16'd1500});
        // undefined codes still emit a snapshot
        for (int c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++) begin
            ev.code   = CMD_W'(c);
            ev.rtt    = RTT_W'($urandom);
            ev.nbytes = BCNT_W'($urandom);
            pending_events.push_back(ev);
        end
        pending_events.push_back('{CMD_TICK, RTT_ALL_ONES, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_LOST, '0, '0});
        pending_events.push_back('{CMD_SENT, RTT_ALL_ONES, BYTES_ALL_ONES});
        pending_events.push_back('{CMD_SENT, '0, 16'd64});

        // random segments, each with its own event mix and rtt flavor
        seg_left = 0;
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (seg_left == 0) begin
                wt_rtt   = $urandom_range(0, 10);
                wt_sent  = $urandom_range(1, 10);
                wt_recv  = $urandom_range(0, 10);
                wt_lost  = $urandom_range(0, 10);
                wt_tick  = $urandom_range(0, 3);
                wt_undef = $urandom_range(0, 1);
                wt_sum   = wt_rtt + wt_sent + wt_recv + wt_lost + wt_tick + wt_undef;
                rtt_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;

            pick = $urandom_range(0, wt_sum - 1);
            if (pick < wt_rtt)
                ev.code = CMD_RTT;
            else if (pick < wt_rtt + wt_sent)
                ev.code = CMD_SENT;
            else if (pick < wt_rtt + wt_sent + wt_recv)
                ev.code = CMD_RECV;
            else if (pick < wt_rtt + wt_sent + wt_recv + wt_lost)
                ev.code = CMD_LOST;
            else if (pick < wt_sum - wt_undef)
                ev.code = CMD_TICK;
            else
                ev.code = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));

            case ($urandom_range(0, 15))
                0: ev.rtt = '0;
                1: ev.rtt = RTT_ALL_ONES;
                default: begin
                    case (rtt_mode)
                        0: ev.rtt = RTT_W'($urandom_range(0, 3));
                        1: ev.rtt = RTT_W'($urandom);
                        default: ev.rtt = RTT_W'($urandom_range(100, 8000));
                    endcase
                end
            endcase

            case ($urandom_range(0, 7))
                0: ev.nbytes = '0;
                1: ev.nbytes = BYTES_ALL_ONES;
                2, 3: ev.nbytes = BCNT_W'($urandom);
                default: ev.nbytes = BCNT_W'($urandom_range(40, 1500));
            endcase
            pending_events.push_back(ev);
        end

        total_items = pending_events.size();
        calm_from   = total_items - CALM_TAIL;

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // wait for every event to be taken and every snapshot to come back
        while (events_taken < total_items || snapshot_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (snapshot_q.size() != 0) begin
            error_count += snapshot_q.size();
            $display("%0t: %0d snapshots never arrived", $time, snapshot_q.size());
        end

        undef_hits = 0;
        for (int c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++)
            undef_hits += code_hits[c];
        $display("events: %0d rtt, %0d sent, %0d received, %0d lost, %0d ticks, %0d undefined",
                 code_hits[CMD_RTT], code_hits[CMD_SENT], code_hits[CMD_RECV],
                 code_hits[CMD_LOST], code_hits[CMD_TICK], undef_hits);
        $display("snapshots compared: %0d, mismatches: %0d", snapshots_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lsm_pkg.sv
hdl/lsm_divider.sv
hdl/lsm_datapath.sv
hdl/lsm_ctrl.sv
hdl/link_statistics_monitor.sv
tb/testbench.sv
